/* design/amr_pkg.sv */
// ----------------------------------------------------------------------------
// Azimuthal mode reconstruction package
// Shared word types, widths, register indexes and the trig table generator.
// ----------------------------------------------------------------------------
package amr_pkg;

    // Field widths of the input and output words.
    localparam int THETA_W         = 7;
    localparam int COEF_W          = 32;
    localparam int TRIG_W          = 16;
    localparam int PROD_W          = COEF_W + TRIG_W;
    localparam int SUM_W           = 52;
    localparam int NUM_FIELD_MODES = 5;
    localparam int NUM_TERMS       = NUM_FIELD_MODES + 1;
    localparam int FRAC_SHIFT      = 15;
    localparam int STAGES          = 7;

    // Configuration port.
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int MODE_COUNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_NEGATE = CFG_IDX_W'(1);

    localparam logic [MODE_COUNT_W-1:0] MODE_COUNT_RESET = MODE_COUNT_W'(1);

    // Rounding offset added before the final shift to Q15.16.
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(16384);

    // Angle pi/2 in Q2.30 and the number of series terms of the sine.
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
    localparam int              SERIES_TERMS = 9;

    // Input word: theta index and the mode coefficients.
    typedef struct packed {
        logic [THETA_W-1:0]       theta_index;
        logic signed [COEF_W-1:0] mode_zero;
        logic signed [COEF_W-1:0] real_one;
        logic signed [COEF_W-1:0] imag_one;
        logic signed [COEF_W-1:0] real_two;
        logic signed [COEF_W-1:0] imag_two;
        logic signed [COEF_W-1:0] real_three;
        logic signed [COEF_W-1:0] imag_three;
        logic signed [COEF_W-1:0] real_four;
        logic signed [COEF_W-1:0] imag_four;
        logic signed [COEF_W-1:0] real_five;
        logic signed [COEF_W-1:0] imag_five;
    } t_in_word;

    // Output word: saturated field value and the clamp flag.
    typedef struct packed {
        logic signed [COEF_W-1:0] field_value;
        logic                     saturated;
    } t_out_word;

    // Restoring division, used only while building constant tables.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sine (cos_sel low) or cosine (cos_sel high) of 2pi*a/p in Q1.15,
    // from a quadrant fold and a nine-term Taylor series in Q2.30.
    function automatic logic signed [TRIG_W-1:0] trig_value(input int unsigned a,
                                                            input int unsigned p,
                                                            input logic cos_sel);
        longint unsigned pl;
        longint unsigned al;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned num;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned mag;
        longint unsigned den;
        pl   = 64'(p);
        al   = 64'(a);
        quad = udiv64(4 * al, pl);
        rem  = 4 * al - quad * pl;
        quad = (quad + 64'(cos_sel)) & 64'd3;
        num  = quad[0] ? (pl - rem) : rem;
        x    = udiv64(num * HALF_PI_Q30 + (pl >> 1), pl);
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n < SERIES_TERMS; n++) begin
            den  = 64'(2 * n) * 64'(2 * n + 1);
            term = udiv64((term * x2) >> 30, den);
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        mag = (acc + 64'd16384) >> 15;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        if (quad >= 64'd2) begin
            return TRIG_W'(-mag);
        end
        return TRIG_W'(mag);
    endfunction

endpackage

/* design/amr_trig_lookup.sv */
// ----------------------------------------------------------------------------
// Trig lookup stages
// Stage one forms the table address of every mode, stage two reads the sine
// and cosine tables and applies the mode mask and the imaginary sign.
// ----------------------------------------------------------------------------
module amr_trig_lookup #(
    parameter int THETA_NODES = 100,
    parameter int MAX_MODES   = 5
) (
    input  logic                                 i_clk,
    input  logic [1:0]                           i_en,
    input  amr_pkg::t_in_word                    i_word,
    input  logic [MAX_MODES-1:0]                 i_mode_en,
    input  logic                                 i_imag_negate,
    output amr_pkg::t_in_word                    o_word,
    output logic signed [amr_pkg::TRIG_W-1:0]    o_cos [MAX_MODES],
    output logic signed [amr_pkg::TRIG_W-1:0]    o_sin [MAX_MODES]
);
    import amr_pkg::*;

    localparam int P         = THETA_NODES - 1;
    localparam int AW        = (P > 1) ? $clog2(P) : 1;
    localparam int IDX_DEPTH = 2 ** THETA_W;
    localparam logic [AW:0] P_EXT = (AW + 1)'(P);

    // Constant tables: index reduced modulo P, and sine and cosine per address.
    logic [AW-1:0]              w_mod_tab [IDX_DEPTH];
    logic signed [TRIG_W-1:0]   w_sin_tab [P];
    logic signed [TRIG_W-1:0]   w_cos_tab [P];

    for (genvar g = 0; g < IDX_DEPTH; g++) begin : g_mod_tab
        localparam int MOD_V = g % P;
        assign w_mod_tab[g] = AW'(MOD_V);
    end

    for (genvar g = 0; g < P; g++) begin : g_trig_tab
        localparam logic signed [TRIG_W-1:0] SIN_V = trig_value(g, P, 1'b0);
        localparam logic signed [TRIG_W-1:0] COS_V = trig_value(g, P, 1'b1);
        assign w_sin_tab[g] = SIN_V;
        assign w_cos_tab[g] = COS_V;
    end

    // Addresses of modes two and up follow from the mode one address by
    // a modular add.
    logic [AW-1:0] n_addr [MAX_MODES];
    logic [AW:0]   w_addr_sum [MAX_MODES];

    always_comb begin
        n_addr[0]     = w_mod_tab[i_word.theta_index];
        w_addr_sum[0] = {1'b0, n_addr[0]};
        for (int k = 1; k < MAX_MODES; k++) begin
            w_addr_sum[k] = {1'b0, n_addr[k-1]} + {1'b0, n_addr[0]};
            if (w_addr_sum[k] >= P_EXT) begin
                n_addr[k] = AW'(w_addr_sum[k] - P_EXT);
            end else begin
                n_addr[k] = AW'(w_addr_sum[k]);
            end
        end
    end

    logic [AW-1:0] r_addr [MAX_MODES];
    t_in_word      r_word1;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_word1 <= i_word;
            r_addr  <= n_addr;
        end
    end

    // Table read; unused modes read as zero and the imaginary sign is folded
    // into the sine.
    logic signed [TRIG_W-1:0] n_cos [MAX_MODES];
    logic signed [TRIG_W-1:0] n_sin [MAX_MODES];

    always_comb begin
        for (int k = 0; k < MAX_MODES; k++) begin
            if (i_mode_en[k]) begin
                n_cos[k] = w_cos_tab[r_addr[k]];
                n_sin[k] = i_imag_negate ? -w_sin_tab[r_addr[k]] : w_sin_tab[r_addr[k]];
            end else begin
                n_cos[k] = '0;
                n_sin[k] = '0;
            end
        end
    end

    logic signed [TRIG_W-1:0] r_cos [MAX_MODES];
    logic signed [TRIG_W-1:0] r_sin [MAX_MODES];
    t_in_word                 r_word2;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_word2 <= r_word1;
            r_cos   <= n_cos;
            r_sin   <= n_sin;
        end
    end

    assign o_word = r_word2;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

/* design/amr_mode_lane.sv */
// ----------------------------------------------------------------------------
// Mode lane
// Multiplies one mode's real and imaginary parts by cosine and sine, then
// adds the two products.
// ----------------------------------------------------------------------------
module amr_mode_lane (
    input  logic                                i_clk,
    input  logic [1:0]                          i_en,
    input  logic signed [amr_pkg::COEF_W-1:0]   i_real,
    input  logic signed [amr_pkg::COEF_W-1:0]   i_imag,
    input  logic signed [amr_pkg::TRIG_W-1:0]   i_cos,
    input  logic signed [amr_pkg::TRIG_W-1:0]   i_sin,
    output logic signed [amr_pkg::SUM_W-1:0]    o_sum
);
    import amr_pkg::*;

    // Product stage: both products are exact in Q.31.
    logic signed [PROD_W-1:0] n_prod_re;
    logic signed [PROD_W-1:0] n_prod_im;
    logic signed [PROD_W-1:0] r_prod_re;
    logic signed [PROD_W-1:0] r_prod_im;

    assign n_prod_re = i_real * i_cos;
    assign n_prod_im = i_imag * i_sin;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod_re <= n_prod_re;
            r_prod_im <= n_prod_im;
        end
    end

    // Lane sum stage.
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] r_sum;

    assign n_sum = SUM_W'(r_prod_re) + SUM_W'(r_prod_im);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

/* design/amr_sum_sat.sv */
// ----------------------------------------------------------------------------
// Sum and saturate
// Adds mode zero and the lane sums over two stages, rounds to Q15.16 and
// clamps to 32 bits in the output register.
// ----------------------------------------------------------------------------
module amr_sum_sat (
    input  logic                              i_clk,
    input  logic [2:0]                        i_en,
    input  logic signed [amr_pkg::SUM_W-1:0]  i_terms [amr_pkg::NUM_TERMS],
    output amr_pkg::t_out_word                o_word
);
    import amr_pkg::*;

    localparam int NUM_PAIRS = NUM_TERMS / 2;
    localparam int SHIFT_W   = SUM_W - FRAC_SHIFT;

    localparam logic signed [SHIFT_W-1:0] SAT_MAX = {{(SHIFT_W - COEF_W + 1){1'b0}},
                                                     {(COEF_W - 1){1'b1}}};
    localparam logic signed [SHIFT_W-1:0] SAT_MIN = {{(SHIFT_W - COEF_W + 1){1'b1}},
                                                     {(COEF_W - 1){1'b0}}};

    // First adder level: pairs of terms.
    logic signed [SUM_W-1:0] n_pair [NUM_PAIRS];
    logic signed [SUM_W-1:0] r_pair [NUM_PAIRS];

    always_comb begin
        for (int k = 0; k < NUM_PAIRS; k++) begin
            n_pair[k] = i_terms[2*k] + i_terms[2*k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pair <= n_pair;
        end
    end

    // Second level: total plus the rounding offset.
    logic signed [SUM_W-1:0] n_acc;
    logic signed [SUM_W-1:0] r_acc;

    always_comb begin
        n_acc = ROUND_HALF;
        for (int k = 0; k < NUM_PAIRS; k++) begin
            n_acc = n_acc + r_pair[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_acc <= n_acc;
        end
    end

    // Floor shift to Q15.16 and clamp.
    logic signed [SHIFT_W-1:0] w_shift;
    t_out_word                 n_out;
    t_out_word                 r_out;

    assign w_shift = SHIFT_W'(r_acc >>> FRAC_SHIFT);

    always_comb begin
        if (w_shift > SAT_MAX) begin
            n_out.field_value = COEF_W'(SAT_MAX);
            n_out.saturated   = 1'b1;
        end else if (w_shift < SAT_MIN) begin
            n_out.field_value = COEF_W'(SAT_MIN);
            n_out.saturated   = 1'b1;
        end else begin
            n_out.field_value = COEF_W'(w_shift);
            n_out.saturated   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_out <= n_out;
        end
    end

    assign o_word = r_out;

endmodule

/* design/azimuthal_mode_reconstruction_unit.sv */
// ----------------------------------------------------------------------------
// Azimuthal mode reconstruction unit: a 7-stage pipeline from input accept
// to output valid. Throughput is one word per cycle when no stage is held;
// stalls hold only the stages that cannot drain into a bubble.
// Synchronous active-low reset empties the pipe, mode_count = 1, sign plus.
// ----------------------------------------------------------------------------
module azimuthal_mode_reconstruction_unit #(
    parameter int THETA_NODES = 100,
    parameter int MAX_MODES   = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  amr_pkg::t_in_word                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output amr_pkg::t_out_word                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [amr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [amr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import amr_pkg::*;

    // Configuration registers; writes are always taken.
    logic [MODE_COUNT_W-1:0] r_mode_count;
    logic                    r_imag_negate;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_count  <= MODE_COUNT_RESET;
            r_imag_negate <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MODE_COUNT:  r_mode_count  <= i_cfg_data[MODE_COUNT_W-1:0];
                REG_IMAG_NEGATE: r_imag_negate <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Mode mask: counts above the lane count act as the lane count.
    logic [MODE_COUNT_W-1:0] w_modes;
    logic [MAX_MODES-1:0]    w_mode_en;

    always_comb begin
        w_modes = (r_mode_count > MODE_COUNT_W'(MAX_MODES)) ?
                  MODE_COUNT_W'(MAX_MODES) : r_mode_count;
        for (int k = 0; k < MAX_MODES; k++) begin
            w_mode_en[k] = (MODE_COUNT_W'(k + 1) <= w_modes);
        end
    end

    // Stage enables: a stage loads when it is empty or its word moves on.
    logic [STAGES:1] r_vld;
    logic [STAGES:1] n_vld;
    logic [STAGES:1] w_en;

    always_comb begin
        w_en[STAGES] = !r_vld[STAGES] || !i_out_stall;
        for (int k = STAGES - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[1] = w_en[1] ? i_in_valid : r_vld[1];
        for (int k = 2; k <= STAGES; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = !w_en[1];
    assign o_out_valid = r_vld[STAGES];

    // Stages one and two: addresses and trig values.
    t_in_word                 w_word2;
    logic signed [TRIG_W-1:0] w_cos [MAX_MODES];
    logic signed [TRIG_W-1:0] w_sin [MAX_MODES];

    amr_trig_lookup #(
        .THETA_NODES (THETA_NODES),
        .MAX_MODES   (MAX_MODES)
    ) u_trig_lookup (
        .i_clk         (i_clk),
        .i_en          (w_en[2:1]),
        .i_word        (i_in_data),
        .i_mode_en     (w_mode_en),
        .i_imag_negate (r_imag_negate),
        .o_word        (w_word2),
        .o_cos         (w_cos),
        .o_sin         (w_sin)
    );

    // Coefficients of each mode in lane order.
    logic signed [COEF_W-1:0] w_re [NUM_FIELD_MODES];
    logic signed [COEF_W-1:0] w_im [NUM_FIELD_MODES];

    always_comb begin
        w_re[0] = w_word2.real_one;
        w_im[0] = w_word2.imag_one;
        w_re[1] = w_word2.real_two;
        w_im[1] = w_word2.imag_two;
        w_re[2] = w_word2.real_three;
        w_im[2] = w_word2.imag_three;
        w_re[3] = w_word2.real_four;
        w_im[3] = w_word2.imag_four;
        w_re[4] = w_word2.real_five;
        w_im[4] = w_word2.imag_five;
    end

    // Stages three and four: one lane per mode.
    logic signed [SUM_W-1:0] w_lane_sum [MAX_MODES];

    for (genvar g = 0; g < MAX_MODES; g++) begin : g_lane
        amr_mode_lane u_mode_lane (
            .i_clk  (i_clk),
            .i_en   (w_en[4:3]),
            .i_real (w_re[g]),
            .i_imag (w_im[g]),
            .i_cos  (w_cos[g]),
            .i_sin  (w_sin[g]),
            .o_sum  (w_lane_sum[g])
        );
    end

    // Mode zero travels alongside the lanes.
    logic signed [COEF_W-1:0] r_mode_zero3;
    logic signed [COEF_W-1:0] r_mode_zero4;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_mode_zero3 <= w_word2.mode_zero;
        end
        if (w_en[4]) begin
            r_mode_zero4 <= r_mode_zero3;
        end
    end

    // Terms of the final sum, mode zero scaled to Q.31.
    logic signed [SUM_W-1:0] w_terms [NUM_TERMS];

    always_comb begin
        w_terms[0] = {{(SUM_W - COEF_W - FRAC_SHIFT){r_mode_zero4[COEF_W-1]}},
                      r_mode_zero4, {FRAC_SHIFT{1'b0}}};
        for (int k = 0; k < NUM_FIELD_MODES; k++) begin
            if (k < MAX_MODES) begin
                w_terms[k+1] = w_lane_sum[k];
            end else begin
                w_terms[k+1] = '0;
            end
        end
    end

    // Stages five to seven: adder tree, rounding and clamp.
    amr_sum_sat u_sum_sat (
        .i_clk   (i_clk),
        .i_en    (w_en[7:5]),
        .i_terms (w_terms),
        .o_word  (o_out_data)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Azimuthal mode reconstruction unit testbench
// Drives input words through the stall handshake and predicts each field
// value from its own sine and cosine tables. Every output word is checked
// field by field against the oldest pending prediction. Directed cases cover
// the coefficient extremes, theta wrap, imaginary sign and mode count limits.
// Random traffic then runs with sender gaps, receiver stalls and full rate.
// ----------------------------------------------------------------------------
module tb;
    import amr_pkg::*;

    localparam int THETA_NODES  = 100;
    localparam int ROM_DEPTH    = THETA_NODES - 1;
    localparam int DRAIN_CYCLES = STAGES + 3;
    localparam int BURST_WORDS  = 235;
    localparam int RECONFIG_GAP = 60;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(65536);
    localparam longint FIELD_MAX = 64'sd2147483647;
    localparam longint FIELD_MIN = -64'sd2147483648;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Local copy of the configuration registers.
    logic [MODE_COUNT_W-1:0] cfg_modes  = MODE_COUNT_RESET;
    logic                    cfg_negate = 1'b0;

    // Sine and cosine tables in Q1.15, one entry per angle step.
    int sin_q15 [ROM_DEPTH];
    int cos_q15 [ROM_DEPTH];

    // Predicted output words, oldest first.
    t_out_word pending_fields [$];
    t_out_word due_word;

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int out_stall_pct  = 0;

    azimuthal_mode_reconstruction_unit #(
        .THETA_NODES(THETA_NODES),
        .MAX_MODES  (NUM_FIELD_MODES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // Sine (cos_sel low) or cosine of 2pi*a/(THETA_NODES-1): quadrant fold,
    // then a nine-term Taylor series in Q2.30, rounded to Q1.15.
    function automatic int trig_q15(input int unsigned a, input bit cos_sel);
        longint unsigned p;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned num;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned series;
        longint unsigned mag;
        p    = longint'(ROM_DEPTH);
        quad = (4 * longint'(a)) / p;
        rem  = 4 * longint'(a) - quad * p;
        quad = (quad + longint'(cos_sel)) & 64'd3;
        num  = quad[0] ? (p - rem) : rem;
        x    = (num * HALF_PI_Q30 + p / 2) / p;
        x2   = (x * x) >> 30;
        term   = x;
        series = x;
        for (int n = 1; n < SERIES_TERMS; n++) begin
            term = ((term * x2) >> 30) / (longint'(2 * n) * longint'(2 * n + 1));
            if (n % 2 == 1) begin
                series = series - term;
            end else begin
                series = series + term;
            end
        end
        mag = (series + 64'd16384) >> 15;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return (quad >= 64'd2) ? -int'(mag) : int'(mag);
    endfunction

    // Field value at this word's angle under the current configuration.
    function automatic t_out_word synthesize_field(input t_in_word w);
        logic signed [COEF_W-1:0] re_part [NUM_FIELD_MODES];
        logic signed [COEF_W-1:0] im_part [NUM_FIELD_MODES];
        longint sum;
        longint im_term;
        longint rounded;
        int     addr;
        int     modes;
        t_out_word r;
        re_part = '{w.real_one, w.real_two, w.real_three, w.real_four, w.real_five};
        im_part = '{w.imag_one, w.imag_two, w.imag_three, w.imag_four, w.imag_five};
        modes   = (int'(cfg_modes) > NUM_FIELD_MODES) ? NUM_FIELD_MODES : int'(cfg_modes);
        sum     = longint'(w.mode_zero) * 64'sd32768;
        for (int m = 1; m <= modes; m++) begin
            addr    = (m * int'(w.theta_index)) % ROM_DEPTH;
            sum     = sum + longint'(re_part[m-1]) * longint'(cos_q15[addr]);
            im_term = longint'(im_part[m-1]) * longint'(sin_q15[addr]);
            sum     = cfg_negate ? (sum - im_term) : (sum + im_term);
        end
        // Round half up, then clamp to the 32-bit range.
        rounded     = (sum + 64'sd16384) >>> FRAC_SHIFT;
        r.saturated = 1'b0;
        if (rounded > FIELD_MAX) begin
            rounded     = FIELD_MAX;
            r.saturated = 1'b1;
        end else if (rounded < FIELD_MIN) begin
            rounded     = FIELD_MIN;
            r.saturated = 1'b1;
        end
        r.field_value = rounded[COEF_W-1:0];
        return r;
    endfunction

    // Word with every coefficient set to one value.
    function automatic t_in_word uniform_word(input int theta,
                                              input logic signed [COEF_W-1:0] v);
        t_in_word w;
        w = '{THETA_W'(theta), v, v, v, v, v, v, v, v, v, v, v};
        return w;
    endfunction

    // Coefficient mix: extremes, zero, full random and mid-size values.
    function automatic logic signed [COEF_W-1:0] random_coef();
        case ($urandom_range(9))
            0: begin
                return COEF_MAX;
            end
            1: begin
                return COEF_MIN;
            end
            2: begin
                return '0;
            end
            3, 4, 5: begin
                return COEF_W'($urandom);
            end
            default: begin
                return COEF_W'(int'($urandom_range(2097152)) - 1048576);
            end
        endcase
    endfunction

    // Random word; theta mostly within the nodes, sometimes past them.
    function automatic t_in_word random_word();
        t_in_word w;
        w.theta_index = ($urandom_range(9) == 0) ? THETA_W'($urandom_range(127, 100))
                                                 : THETA_W'($urandom_range(ROM_DEPTH));
        w.mode_zero  = random_coef();
        w.real_one   = random_coef();
        w.imag_one   = random_coef();
        w.real_two   = random_coef();
        w.imag_two   = random_coef();
        w.real_three = random_coef();
        w.imag_three = random_coef();
        w.real_four  = random_coef();
        w.imag_four  = random_coef();
        w.real_five  = random_coef();
        w.imag_five  = random_coef();
        return w;
    endfunction

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Compare each accepted output word with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_fields.size() == 0) begin
                $error("output word with nothing pending: field_value %0d saturated %0b",
                       o_out_data.field_value, o_out_data.saturated);
                mismatch_count++;
            end else begin
                due_word = pending_fields.pop_front();
                if (o_out_data.field_value !== due_word.field_value) begin
                    $error("field_value: expected %0d, got %0d",
                           due_word.field_value, o_out_data.field_value);
                    mismatch_count++;
                end
                if (o_out_data.saturated !== due_word.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           due_word.saturated, o_out_data.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one word; called and returns at a falling edge.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pending_fields.push_back(synthesize_field(w));
        @(negedge i_clk);
    endtask

    // Hold off input until every pending word has come out and the pipe is empty.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_fields.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One register write; leaves the write valid high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx == REG_MODE_COUNT) begin
            cfg_modes = data[MODE_COUNT_W-1:0];
        end else if (idx == REG_IMAG_NEGATE) begin
            cfg_negate = data[0];
        end
        @(negedge i_clk);
    endtask

    // Write both registers with random upper bits, then a write to an
    // unused index that must be ignored.
    task automatic set_config(input int modes, input int negate);
        logic [CFG_DATA_W-1:0] d_modes;
        logic [CFG_DATA_W-1:0] d_negate;
        d_modes  = CFG_DATA_W'($urandom);
        d_negate = CFG_DATA_W'($urandom);
        d_modes[MODE_COUNT_W-1:0] = MODE_COUNT_W'(modes);
        d_negate[0]               = 1'(negate);
        write_reg(REG_MODE_COUNT, d_modes);
        write_reg(REG_IMAG_NEGATE, d_negate);
        write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1,
                                            int'(REG_IMAG_NEGATE) + 1)),
                  CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Coefficient extremes at the reset configuration and at all modes.
    task automatic test_field_extremes();
        send_word(uniform_word(0, COEF_MAX));
        wait_drain();
        set_config(NUM_FIELD_MODES, 0);
        send_word(uniform_word(0, '0));
        send_word(uniform_word(0, COEF_MAX));
        send_word(uniform_word(0, COEF_MIN));
        send_word(uniform_word(50, COEF_MIN));
        send_word(random_word());
        wait_drain();
    endtask

    // Last node, indexes past the nodes, and quarter turns.
    task automatic test_theta_wrap();
        send_word(uniform_word(ROM_DEPTH, COEF_ONE));
        send_word(uniform_word(1, COEF_ONE));
        send_word(uniform_word(THETA_NODES, COEF_ONE));
        send_word(uniform_word(127, COEF_W'(32'h0003_1415)));
        send_word(uniform_word(25, COEF_ONE));
        send_word(uniform_word(74, COEF_W'(-32'sd98304)));
        wait_drain();
    endtask

    // Imaginary terms subtracted instead of added.
    task automatic test_imag_sign();
        set_config(NUM_FIELD_MODES, 1);
        send_word(uniform_word(25, COEF_ONE));
        send_word(uniform_word(75, COEF_MAX));
        send_word(uniform_word(12, COEF_MIN));
        send_word(random_word());
        wait_drain();
    endtask

    // Mode counts above the limit clamp; zero gives mode zero only.
    task automatic test_mode_count_limits();
        set_config(7, 1);
        send_word(uniform_word(33, COEF_W'(32'h0001_2345)));
        send_word(random_word());
        wait_drain();
        set_config(6, 0);
        send_word(random_word());
        wait_drain();
        set_config(0, 0);
        send_word(uniform_word(40, COEF_MAX));
        send_word(uniform_word(40, COEF_MIN));
        send_word(random_word());
        wait_drain();
    endtask

    // Random words with a fresh configuration every so often.
    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % RECONFIG_GAP == 0) begin
                wait_drain();
                set_config($urandom_range((1 << MODE_COUNT_W) - 1), $urandom_range(1));
            end
            send_word(random_word());
        end
        wait_drain();
    endtask

    task automatic test_random_sender_gaps();
        send_idle_pct = 35;
        out_stall_pct = 66;
        random_burst(BURST_WORDS);
    endtask

    task automatic test_random_receiver_stalls();
        send_idle_pct = 66;
        out_stall_pct = 35;
        random_burst(BURST_WORDS);
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        out_stall_pct = 0;
        random_burst(BURST_WORDS);
    endtask

    // Test sequence.
    initial begin
        for (int a = 0; a < ROM_DEPTH; a++) begin
            sin_q15[a] = trig_q15(a, 1'b0);
            cos_q15[a] = trig_q15(a, 1'b1);
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_field_extremes();
        test_theta_wrap();
        test_imag_sign();
        test_mode_count_limits();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_full_rate();

        wait_drain();
        if (mismatch_count == 0 && pending_fields.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
design/amr_pkg.sv
design/amr_trig_lookup.sv
design/amr_mode_lane.sv
design/amr_sum_sat.sv
design/azimuthal_mode_reconstruction_unit.sv
test/tb.sv
